// ----- sv/fwwd_pkg.sv -----
`timescale 1ns / 1ps

package fwwd_pkg;

  // Longest word the block can hold as a candidate.
  localparam int unsigned MAX_WORD = 16;

  // Fixed widths of the register file and the text bytes.
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned REG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_CHARS_LOW  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHARS_HIGH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH     = 2'd2;

  // Source of the next result loaded into the output register.
  typedef enum logic [1:0] {
    LD_NONE,
    LD_NOW,
    LD_HELD,
    LD_CHAR
  } load_sel_e;

  typedef struct packed {
    logic      accept;
    load_sel_e load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rel_nz;
    logic item_now;
    logic emit_q;
    logic final_held;
  } ctrl_stat_t;

endpackage

// ----- sv/first_whole_word_deleter.sv -----
`timescale 1ns / 1ps
// A byte that passes straight through is loaded into the output register when it is accepted.
// Throughput: one byte per cycle while bytes pass through or extend a candidate match and the output is free.
// A byte that fails a candidate ties up the input while it is accepted, while each held
// byte is released in arrival order, and while the byte itself is sent after them.
// Reset (rst_ni low, asynchronous) clears the stream state and sets the word to length one.

module first_whole_word_deleter #(
  parameter int unsigned MaxWord = fwwd_pkg::MAX_WORD
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [fwwd_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [fwwd_pkg::CFG_W-1:0]     cfg_wdata_i,
  // Input text stream.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fwwd_pkg::CHAR_W-1:0]    in_char_i,
  input  logic                           in_last_i,
  // Output text stream.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fwwd_pkg::CHAR_W-1:0]    out_char_o,
  output logic                           has_char_o,
  output logic                           out_last_o,
  output logic                           deleted_o,
  output logic                           word_error_o
);

  // The controller sequences each input transaction: bytes that pass straight
  // through, or the marker that closes a text, go to the output register at once.
  // When a candidate fails, the held bytes are released one per cycle while the output
  // register is free, followed by the byte that broke the candidate, and input is stalled meanwhile.
  fwwd_pkg::ctrl_cmd_t  cmd;
  fwwd_pkg::ctrl_stat_t stat;

  fwwd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // The datapath keeps the word registers, the candidate bytes and the match
  // state, decides per byte what to release, and owns the output payload.
  fwwd_dp #(
    .MaxWord (MaxWord)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_char_i    (in_char_i),
    .in_last_i    (in_last_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_char_o   (out_char_o),
    .has_char_o   (has_char_o),
    .out_last_o   (out_last_o),
    .deleted_o    (deleted_o),
    .word_error_o (word_error_o)
  );

endmodule

// ----- sv/fwwd_dp.sv -----
`timescale 1ns / 1ps

module fwwd_dp #(
  parameter int unsigned MaxWord = fwwd_pkg::MAX_WORD
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fwwd_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fwwd_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic [fwwd_pkg::CHAR_W-1:0]      in_char_i,
  input  logic                             in_last_i,
  input  fwwd_pkg::ctrl_cmd_t              cmd_i,
  output fwwd_pkg::ctrl_stat_t             stat_o,
  output logic [fwwd_pkg::CHAR_W-1:0]      out_char_o,
  output logic                             has_char_o,
  output logic                             out_last_o,
  output logic                             deleted_o,
  output logic                             word_error_o
);

  localparam int unsigned CntW  = $clog2(MaxWord + 1);
  localparam int unsigned IdxW  = (MaxWord > 1) ? $clog2(MaxWord) : 1;
  localparam int unsigned LenW  = fwwd_pkg::LEN_W;
  localparam int unsigned CharW = fwwd_pkg::CHAR_W;
  localparam int unsigned CfgW  = fwwd_pkg::CFG_W;

  function automatic logic is_delim(input logic [CharW-1:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32 ||
           (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  // Configuration registers.
  logic [CfgW-1:0] chars_lo_q, chars_hi_q;
  logic [LenW-1:0] wlen_q;

  // Stream state.
  logic [CntW-1:0]  held_cnt_q;
  logic             at_start_q, skip_q, done_q;
  logic [CharW-1:0] held_q [MaxWord];

  // Facts of the accepted byte kept for the release sequence.
  logic [CntW-1:0]  rel_q;
  logic [IdxW-1:0]  idx_q;
  logic             emit_q, last_q, del_q, err_q;
  logic [CharW-1:0] char_q;

  // Output register.
  logic [CharW-1:0] out_char_q;
  logic             has_q, out_last_q, deleted_q, werr_q;

  logic [2*CfgW-1:0] word;
  logic [LenW-1:0]   len5, hc_ext;
  logic [CntW-1:0]   len, hc_d, rel;
  logic [CharW-1:0]  wbyte;
  logic              err, dl, flush, emit, wr_held, restart;
  logic              start_d, skip_d, done_d, final_held;

  always_comb begin
    word   = {chars_hi_q, chars_lo_q};
    len5   = (wlen_q > LenW'(MaxWord)) ? LenW'(MaxWord) : wlen_q;
    len    = CntW'(len5);
    err    = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (LenW'(i) < len5 && is_delim(word[i*8 +: 8])) begin
        err = 1'b1;
      end
    end
    hc_ext = LenW'(held_cnt_q);
    wbyte  = word[{hc_ext[3:0], 3'b000} +: 8];
    dl     = is_delim(in_char_i);

    flush   = 1'b0;
    emit    = 1'b0;
    wr_held = 1'b0;
    restart = 1'b0;
    rel     = held_cnt_q;
    hc_d    = held_cnt_q;
    start_d = at_start_q;
    skip_d  = skip_q;
    done_d  = done_q;

    if (done_q || err) begin
      flush = 1'b1;
      emit  = 1'b1;
    end else if (skip_q || !at_start_q) begin
      flush   = 1'b1;
      emit    = 1'b1;
      restart = 1'b1;
    end else if (held_cnt_q == len) begin
      if (dl) begin
        emit   = 1'b1;
        hc_d   = '0;
        done_d = 1'b1;
      end else begin
        flush   = 1'b1;
        emit    = 1'b1;
        restart = 1'b1;
      end
    end else if (held_cnt_q < len && in_char_i == wbyte) begin
      wr_held = 1'b1;
      hc_d    = held_cnt_q + CntW'(1);
      if (in_last_i) begin
        if (hc_d == len) begin
          hc_d   = '0;
          done_d = 1'b1;
        end else begin
          flush = 1'b1;
          rel   = held_cnt_q + CntW'(1);
        end
      end
    end else begin
      flush   = 1'b1;
      emit    = 1'b1;
      restart = 1'b1;
    end

    if (restart) begin
      start_d = dl;
      skip_d  = !dl;
    end
    if (flush) begin
      hc_d = '0;
    end

    final_held = (CntW'(idx_q) == rel_q - CntW'(1));

    stat_o.rel_nz     = flush && (rel != '0);
    stat_o.item_now   = emit || in_last_i;
    stat_o.emit_q     = emit_q;
    stat_o.final_held = final_held;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_lo_q <= '0;
      chars_hi_q <= '0;
      wlen_q     <= LenW'(1);
      held_cnt_q <= '0;
      at_start_q <= 1'b1;
      skip_q     <= 1'b0;
      done_q     <= 1'b0;
      rel_q      <= '0;
      idx_q      <= '0;
      emit_q     <= 1'b0;
      last_q     <= 1'b0;
      del_q      <= 1'b0;
      err_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fwwd_pkg::REG_CHARS_LOW:  chars_lo_q <= cfg_wdata_i;
          fwwd_pkg::REG_CHARS_HIGH: chars_hi_q <= cfg_wdata_i;
          fwwd_pkg::REG_LENGTH:     wlen_q     <= cfg_wdata_i[LenW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        // The final byte of a text returns the stream state to its start.
        held_cnt_q <= in_last_i ? '0 : hc_d;
        at_start_q <= in_last_i || start_d;
        skip_q     <= !in_last_i && skip_d;
        done_q     <= !in_last_i && done_d;
        rel_q      <= flush ? rel : '0;
        idx_q      <= '0;
        emit_q     <= emit;
        last_q     <= in_last_i;
        del_q      <= done_d;
        err_q      <= err;
      end else if (cmd_i.load == fwwd_pkg::LD_HELD) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // Candidate bytes and payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      char_q <= in_char_i;
      if (wr_held) begin
        held_q[held_cnt_q[IdxW-1:0]] <= in_char_i;
      end
    end
    case (cmd_i.load)
      fwwd_pkg::LD_NOW: begin
        out_char_q <= emit ? in_char_i : '0;
        has_q      <= emit;
        out_last_q <= in_last_i;
        deleted_q  <= in_last_i && done_d;
        werr_q     <= in_last_i && err;
      end
      fwwd_pkg::LD_HELD: begin
        out_char_q <= held_q[idx_q];
        has_q      <= 1'b1;
        out_last_q <= last_q && final_held && !emit_q;
        deleted_q  <= last_q && final_held && !emit_q && del_q;
        werr_q     <= last_q && final_held && !emit_q && err_q;
      end
      fwwd_pkg::LD_CHAR: begin
        out_char_q <= char_q;
        has_q      <= 1'b1;
        out_last_q <= last_q;
        deleted_q  <= last_q && del_q;
        werr_q     <= last_q && err_q;
      end
      default: ;
    endcase
  end

  assign out_char_o   = out_char_q;
  assign has_char_o   = has_q;
  assign out_last_o   = out_last_q;
  assign deleted_o    = deleted_q;
  assign word_error_o = werr_q;

`ifndef NO_ASSERTIONS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q <= CntW'(MaxWord))
    else $error("held byte count exceeds the word capacity");

  a_release_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load == fwwd_pkg::LD_HELD |-> CntW'(idx_q) < rel_q)
    else $error("release index beyond the held bytes");
`endif

endmodule

// ----- sv/fwwd_ctrl.sv -----
`timescale 1ns / 1ps

module fwwd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fwwd_pkg::ctrl_cmd_t  cmd_o,
  input  fwwd_pkg::ctrl_stat_t stat_i
);

  typedef enum logic [1:0] {
    S_RUN,
    S_FLUSH,
    S_CHAR
  } state_e;

  state_e              state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                slot_free, accept;
  fwwd_pkg::load_sel_e load;

  always_comb begin
    slot_free  = !out_valid_q || out_ready_i;
    in_ready_o = (state_q == S_RUN) && slot_free;
    accept     = in_valid_i && in_ready_o;
    state_d    = state_q;
    load       = fwwd_pkg::LD_NONE;
    unique case (state_q)
      S_RUN: begin
        if (accept) begin
          if (stat_i.rel_nz) begin
            state_d = S_FLUSH;
          end else if (stat_i.item_now) begin
            load = fwwd_pkg::LD_NOW;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          load = fwwd_pkg::LD_HELD;
          if (stat_i.final_held) begin
            state_d = stat_i.emit_q ? S_CHAR : S_RUN;
          end
        end
      end
      S_CHAR: begin
        if (slot_free) begin
          load    = fwwd_pkg::LD_CHAR;
          state_d = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
    out_valid_d  = (load != fwwd_pkg::LD_NONE) || (out_valid_q && !out_ready_i);
    cmd_o.accept = accept;
    cmd_o.load   = load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load != fwwd_pkg::LD_NONE |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while occupied");

  a_enter_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && stat_i.rel_nz |=> state_q == S_FLUSH)
    else $error("held bytes to release but no release sequence");

  a_char_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHAR |-> stat_i.emit_q)
    else $error("trailing byte state without a byte to send");
`endif

endmodule

// ----- tb/first_whole_word_deleter_test.sv -----
`timescale 1ns / 1ps

module first_whole_word_deleter_test;

  // Quiet time at the end, long enough for a failed candidate of the longest word to
  // finish its release and for any other work in flight to come out.
  localparam int unsigned DRAIN_CYCLES = fwwd_pkg::MAX_WORD + 4;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned RANDOM_BYTES = 300;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned HOLD_AFTER   = 40;

  // One output transaction as the block presents it.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_ch;
    logic       fin;
    logic       del;
    logic       err;
  } text_out_t;

  // The directed part is a list of rows. A word row rewrites all three registers,
  // a byte row offers one text byte. Byte rows flagged as typed carry their single
  // expected transaction, written out by hand.
  typedef enum logic {
    ROW_WORD,
    ROW_BYTE
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic [7:0]  ch;
    bit          fin;
    bit          typed;
    text_out_t   want;
  } stim_row_t;

  logic                           clk_i;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_q    = 1'b0;
  logic [fwwd_pkg::REG_IDX_W-1:0] cfg_idx_q   = fwwd_pkg::REG_CHARS_LOW;
  logic [fwwd_pkg::CFG_W-1:0]     cfg_wdata_q = '0;
  logic                           in_valid_q  = 1'b0;
  logic [fwwd_pkg::CHAR_W-1:0]    in_char_q   = '0;
  logic                           in_last_q   = 1'b0;
  logic                           out_ready_q = 1'b0;
  logic                           in_ready_o;
  logic                           out_valid_o;
  logic [fwwd_pkg::CHAR_W-1:0]    out_char_o;
  logic                           has_char_o;
  logic                           out_last_o;
  logic                           deleted_o;
  logic                           word_error_o;

  first_whole_word_deleter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_q),
    .cfg_idx_i   (cfg_idx_q),
    .cfg_wdata_i (cfg_wdata_q),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (in_ready_o),
    .in_char_i   (in_char_q),
    .in_last_i   (in_last_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_q),
    .out_char_o  (out_char_o),
    .has_char_o  (has_char_o),
    .out_last_o  (out_last_o),
    .deleted_o   (deleted_o),
    .word_error_o(word_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mirror of the block's registers and stream state.
  logic [63:0] word_lo;
  logic [63:0] word_hi;
  logic [4:0]  wlen_mirror;
  logic [7:0]  cand_bytes [fwwd_pkg::MAX_WORD];
  int unsigned cand_count;
  bit          at_start;
  bit          in_skip;
  bit          word_gone;

  // Transactions produced by the byte just predicted, and all transactions that the
  // block still owes, oldest first.
  text_out_t step_bytes [$];
  text_out_t due_bytes [$];

  // Bytes of the text under construction in the random part.
  logic [7:0] text_q [$];
  stim_row_t  dir_rows [$];

  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned texts_sent = 0;
  int unsigned results_seen = 0;
  int unsigned deletions_seen = 0;
  int unsigned word_errors_seen = 0;
  int unsigned words_tried = 0;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Delimiters are the C-locale space and punctuation bytes.
  function automatic bit is_delim(input logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32 ||
           (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic logic [7:0] word_char(input int unsigned i);
    int unsigned k;
    k = i & 15;
    if (k < 8) return word_lo[8*k +: 8];
    return word_hi[8*(k-8) +: 8];
  endfunction

  function automatic text_out_t mk_out(input logic [7:0] ch, input logic has_ch,
                                       input logic fin, input logic del, input logic err);
    text_out_t r;
    r.ch = ch;
    r.has_ch = has_ch;
    r.fin = fin;
    r.del = del;
    r.err = err;
    return r;
  endfunction

  task automatic emit_byte(input logic [7:0] c, input logic has_ch);
    step_bytes.push_back(mk_out(c, has_ch, 1'b0, 1'b0, 1'b0));
  endtask

  // A failed candidate gives back its held bytes in arrival order.
  task automatic release_cand();
    int unsigned i;
    for (i = 0; i < cand_count; i++) emit_byte(cand_bytes[i], 1'b1);
    cand_count = 0;
  endtask

  // After a byte that ends a candidate, a delimiter opens the next candidate and
  // anything else starts a word that can only be passed through.
  task automatic restart_after(input logic [7:0] c);
    at_start = is_delim(c);
    in_skip  = !is_delim(c);
  endtask

  task automatic clear_stream();
    cand_count = 0;
    at_start   = 1'b1;
    in_skip    = 1'b0;
    word_gone  = 1'b0;
  endtask

  // Works out every transaction one accepted text byte causes, into step_bytes.
  task automatic predict_deletion(input logic [7:0] c, input bit fin);
    int unsigned n_len;
    int unsigned i;
    bit          bad;
    text_out_t   tail;
    step_bytes.delete();
    n_len = (wlen_mirror > fwwd_pkg::MAX_WORD) ? fwwd_pkg::MAX_WORD : wlen_mirror;
    bad = 1'b0;
    for (i = 0; i < n_len; i++) if (is_delim(word_char(i))) bad = 1'b1;

    if (word_gone || bad) begin
      // Once a word is gone, or the word itself is illegal, text streams through.
      release_cand();
      emit_byte(c, 1'b1);
    end else if (in_skip || !at_start) begin
      release_cand();
      emit_byte(c, 1'b1);
      restart_after(c);
    end else if (cand_count == n_len) begin
      // The whole word is held: only a delimiter right after it makes it a match,
      // and that delimiter survives.
      if (is_delim(c)) begin
        cand_count = 0;
        emit_byte(c, 1'b1);
        word_gone = 1'b1;
      end else begin
        release_cand();
        emit_byte(c, 1'b1);
        restart_after(c);
      end
    end else if (cand_count < n_len && c == word_char(cand_count)) begin
      cand_bytes[cand_count] = c;
      cand_count++;
      if (fin) begin
        // The end of text also closes a word.
        if (cand_count == n_len) begin
          cand_count = 0;
          word_gone = 1'b1;
        end else begin
          release_cand();
        end
      end
    end else begin
      release_cand();
      emit_byte(c, 1'b1);
      restart_after(c);
    end

    if (fin) begin
      // The final transaction carries the verdict; with nothing left to send it is
      // an empty marker.
      if (step_bytes.size() == 0) emit_byte(8'h00, 1'b0);
      tail = step_bytes.pop_back();
      tail.fin = 1'b1;
      tail.del = word_gone;
      tail.err = bad;
      step_bytes.push_back(tail);
      clear_stream();
    end
  endtask

  // Called only while the block is idle; all three registers are written back to back.
  task automatic write_word(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] len);
    cfg_we_q    <= 1'b1;
    cfg_idx_q   <= fwwd_pkg::REG_CHARS_LOW;
    cfg_wdata_q <= lo;
    @(negedge clk_i);
    cfg_idx_q   <= fwwd_pkg::REG_CHARS_HIGH;
    cfg_wdata_q <= hi;
    @(negedge clk_i);
    cfg_idx_q   <= fwwd_pkg::REG_LENGTH;
    cfg_wdata_q <= {{(fwwd_pkg::CFG_W-fwwd_pkg::LEN_W){1'b0}}, len};
    @(negedge clk_i);
    cfg_we_q    <= 1'b0;
    word_lo     = lo;
    word_hi     = hi;
    wlen_mirror = len;
    words_tried++;
  endtask

  // Waits until every owed transaction is out, then lets any work that produces no
  // result settle before the registers change.
  task automatic settle_idle();
    in_valid_q <= 1'b0;
    while (due_bytes.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Offers one byte after a random gap and records what it must produce once the
  // transaction completes. Entered and left at a falling edge.
  task automatic push_byte(input logic [7:0] c, input bit fin, input bit typed,
                           input text_out_t typed_out);
    int unsigned gap;
    int unsigned i;
    gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_q <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_q <= 1'b1;
    in_char_q  <= c;
    in_last_q  <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    predict_deletion(c, fin);
    if (typed) begin
      due_bytes.push_back(typed_out);
    end else begin
      for (i = 0; i < step_bytes.size(); i++) due_bytes.push_back(step_bytes[i]);
    end
    bytes_sent++;
    if (fin) texts_sent++;
    @(negedge clk_i);
  endtask

  task automatic add_word_row(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len);
    stim_row_t r;
    r.kind = ROW_WORD;
    r.lo = lo;
    r.hi = hi;
    r.len = len;
    r.ch = 8'h00;
    r.fin = 1'b0;
    r.typed = 1'b0;
    r.want = '0;
    dir_rows.push_back(r);
  endtask

  task automatic add_byte_row(input logic [7:0] ch, input bit fin, input bit typed,
                              input text_out_t want);
    stim_row_t r;
    r.kind = ROW_BYTE;
    r.lo = '0;
    r.hi = '0;
    r.len = '0;
    r.ch = ch;
    r.fin = fin;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  function automatic logic [7:0] rand_delim();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (!is_delim(b));
    return b;
  endfunction

  // Word characters come mostly from a four-letter alphabet so that candidates
  // collide often; now and then any non-delimiter byte is used.
  function automatic logic [7:0] rand_word_char();
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) begin
      do b = 8'($urandom_range(0, 255)); while (is_delim(b));
    end else begin
      b = 8'h61 + 8'($urandom_range(0, 3));
    end
    return b;
  endfunction

  // Picks a new word: mostly short legal words, with the longest word, a single
  // character, the empty word, an over-long length, an illegal word and fully random
  // register contents mixed in.
  task automatic pick_word();
    logic [7:0]  w [fwwd_pkg::MAX_WORD];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len5;
    int unsigned mode;
    int unsigned n;
    int unsigned i;
    mode = $urandom_range(0, 19);
    n = $urandom_range(2, 8);
    if (mode == 0) n = 0;
    else if (mode == 1) n = $urandom_range(17, 31);
    else if (mode == 2 || mode == 3) n = fwwd_pkg::MAX_WORD;
    else if (mode == 4 || mode == 5) n = 1;
    for (i = 0; i < fwwd_pkg::MAX_WORD; i++) begin
      if (i < n) w[i] = rand_word_char();
      else w[i] = 8'($urandom_range(0, 255));
    end
    if (mode == 6) w[$urandom_range(0, n - 1)] = rand_delim();
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = w[i];
      hi[8*i +: 8] = w[i+8];
    end
    len5 = 5'(n);
    if (mode == 7) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      len5 = 5'($urandom_range(0, 31));
    end
    write_word(lo, hi, len5);
  endtask

  // Builds a text from tokens: the word itself, a prefix of it, the word with a
  // character glued on, other words and raw bytes, separated by delimiters. A few
  // texts are pure noise.
  task automatic build_text();
    int unsigned eff;
    int unsigned tokens;
    int unsigned kind;
    int unsigned k;
    int unsigned t;
    int unsigned i;
    logic [7:0]  b;
    text_q.delete();
    eff = (wlen_mirror > fwwd_pkg::MAX_WORD) ? fwwd_pkg::MAX_WORD : wlen_mirror;
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(1, 20);
      for (i = 0; i < k; i++) begin
        b = 8'($urandom_range(0, 255));
        text_q.push_back(b);
      end
    end else begin
      if ($urandom_range(0, 3) == 0) text_q.push_back(rand_delim());
      tokens = $urandom_range(1, 5);
      for (t = 0; t < tokens; t++) begin
        kind = $urandom_range(0, 9);
        case (kind)
          0, 1, 2, 3: begin
            for (i = 0; i < eff; i++) text_q.push_back(word_char(i));
          end
          4: begin
            k = (eff > 1) ? $urandom_range(1, eff - 1) : 1;
            for (i = 0; i < k; i++) begin
              if (i < eff) text_q.push_back(word_char(i));
              else text_q.push_back(rand_word_char());
            end
          end
          5: begin
            for (i = 0; i < eff; i++) text_q.push_back(word_char(i));
            text_q.push_back(rand_word_char());
          end
          6, 7: begin
            k = $urandom_range(1, 6);
            for (i = 0; i < k; i++) text_q.push_back(rand_word_char());
          end
          default: begin
            b = 8'($urandom_range(0, 255));
            text_q.push_back(b);
          end
        endcase
        if (t + 1 < tokens || $urandom_range(0, 1) == 1) begin
          k = $urandom_range(1, 2);
          for (i = 0; i < k; i++) text_q.push_back(rand_delim());
        end
      end
      if (text_q.size() == 0) text_q.push_back(rand_word_char());
    end
  endtask

  // Output side: a random stall before each transaction, and one long hold-off once
  // traffic is flowing, so the block fills up and has to push back on its input.
  initial begin : sink
    int unsigned stall;
    text_out_t   want;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 18);
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        stall = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (stall > 0) begin
        out_ready_q <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_q <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      if (out_last_o && deleted_o) deletions_seen++;
      if (out_last_o && word_error_o) word_errors_seen++;
      if (due_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, actual char %h has %b last %b",
                 $time, out_char_o, has_char_o, out_last_o);
      end else begin
        want = due_bytes.pop_front();
        if (want.ch !== out_char_o) begin
          mismatches++;
          $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char_o);
        end
        if (want.has_ch !== has_char_o) begin
          mismatches++;
          $display("%0t: has_char expected %b actual %b", $time, want.has_ch, has_char_o);
        end
        if (want.fin !== out_last_o) begin
          mismatches++;
          $display("%0t: out_last expected %b actual %b", $time, want.fin, out_last_o);
        end
        if (want.del !== deleted_o) begin
          mismatches++;
          $display("%0t: deleted expected %b actual %b", $time, want.del, deleted_o);
        end
        if (want.err !== word_error_o) begin
          mismatches++;
          $display("%0t: word_error expected %b actual %b", $time, want.err, word_error_o);
        end
      end
      // Switch now and then between stalling and taking every transaction at once.
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      @(negedge clk_i);
    end
  end

  initial begin : source
    int unsigned r;
    int unsigned t;
    int unsigned k;
    int unsigned i;
    bit          close;
    text_out_t   none;

    none = '0;
    word_lo     = '0;
    word_hi     = '0;
    wlen_mirror = 5'd1;
    for (i = 0; i < fwwd_pkg::MAX_WORD; i++) cand_bytes[i] = 8'h00;
    clear_stream();

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Out of reset the word is one zero byte.
    add_byte_row(8'h61, 1'b1, 1'b1, mk_out(8'h61, 1'b1, 1'b1, 1'b0, 1'b0));
    // A lone zero byte is the whole word, closed by the end of text: only an empty
    // marker is left to report the deletion.
    add_byte_row(8'h00, 1'b1, 1'b1, mk_out(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    add_byte_row(8'hff, 1'b0, 1'b0, none);
    add_byte_row(8'h00, 1'b1, 1'b0, none);
    // Word "cat": a match closed by a space, then a second one that must stay.
    add_word_row(64'h0000_0000_0074_6163, 64'h0, 5'd3);
    add_byte_row(8'h63, 1'b0, 1'b0, none);
    add_byte_row(8'h61, 1'b0, 1'b0, none);
    add_byte_row(8'h74, 1'b0, 1'b0, none);
    add_byte_row(8'h20, 1'b0, 1'b0, none);
    add_byte_row(8'h63, 1'b0, 1'b0, none);
    add_byte_row(8'h61, 1'b0, 1'b0, none);
    add_byte_row(8'h74, 1'b0, 1'b0, none);
    add_byte_row(8'h2e, 1'b1, 1'b0, none);
    // The whole text is the word.
    add_byte_row(8'h63, 1'b0, 1'b0, none);
    add_byte_row(8'h61, 1'b0, 1'b0, none);
    add_byte_row(8'h74, 1'b1, 1'b1, mk_out(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    // A candidate cut short by the end of text is given back.
    add_byte_row(8'h63, 1'b0, 1'b0, none);
    add_byte_row(8'h61, 1'b1, 1'b0, none);
    // Two bytes held, then the word shrinks under them mid-text.
    add_byte_row(8'h63, 1'b0, 1'b0, none);
    add_byte_row(8'h61, 1'b0, 1'b0, none);
    add_word_row(64'h0000_0000_0074_6163, 64'h0, 5'd1);
    add_byte_row(8'h78, 1'b1, 1'b0, none);
    // The empty word matches at a delimiter, removes nothing, yet reports a deletion.
    add_word_row(64'h0, 64'h0, 5'd0);
    add_byte_row(8'h20, 1'b1, 1'b1, mk_out(8'h20, 1'b1, 1'b1, 1'b1, 1'b0));
    // "a b" holds a space, so the word is illegal and text passes untouched.
    add_word_row(64'h0000_0000_0062_2061, 64'h0, 5'd3);
    add_byte_row(8'h61, 1'b1, 1'b1, mk_out(8'h61, 1'b1, 1'b1, 1'b0, 1'b1));
    // All-ones registers with a length past the limit: sixteen 0xff bytes.
    add_word_row({64{1'b1}}, {64{1'b1}}, 5'd31);
    add_byte_row(8'hff, 1'b0, 1'b0, none);
    add_byte_row(8'hff, 1'b0, 1'b0, none);
    add_byte_row(8'h21, 1'b1, 1'b0, none);

    foreach (dir_rows[j]) begin
      if (dir_rows[j].kind == ROW_WORD) begin
        settle_idle();
        write_word(dir_rows[j].lo, dir_rows[j].hi, dir_rows[j].len);
      end else begin
        push_byte(dir_rows[j].ch, dir_rows[j].fin, dir_rows[j].typed, dir_rows[j].want);
      end
    end

    // Random part: a new word per phase, a few texts per phase. The last text of a
    // phase is sometimes left open, so the word changes in the middle of a text.
    r = bytes_sent;
    while (bytes_sent < r + RANDOM_BYTES) begin
      settle_idle();
      pick_word();
      k = $urandom_range(1, 3);
      for (t = 0; t < k; t++) begin
        build_text();
        tx_burst = ($urandom_range(0, 3) == 0);
        close = (t + 1 < k) || ($urandom_range(0, 6) != 0);
        for (i = 0; i < text_q.size(); i++)
          push_byte(text_q[i], close && (i + 1 == text_q.size()), 1'b0, none);
      end
    end
    // Close whatever text is still open.
    push_byte(8'h2e, 1'b1, 1'b0, none);

    in_valid_q <= 1'b0;
    while (due_bytes.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (due_bytes.size() != 0) begin
      mismatches += due_bytes.size();
      $display("%0t: %0d expected transactions never arrived, first char %h",
               $time, due_bytes.size(), due_bytes[0].ch);
    end

    $display("Sent %0d bytes in %0d texts over %0d word settings; %0d transactions out.",
             bytes_sent, texts_sent, words_tried, results_seen);
    $display("Texts with a deletion: %0d, texts flagged for an illegal word: %0d.",
             deletions_seen, word_errors_seen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/fwwd_pkg.sv
sv/fwwd_dp.sv
sv/fwwd_ctrl.sv
sv/first_whole_word_deleter.sv
tb/first_whole_word_deleter_test.sv
